### design/sadr_pkg.sv
// Shared types and constants for the stream-aware dead-block replacement core.
package sadr_pkg;
   localparam int ADDR_W = 64;
   localparam int SET_FIELD_W = 11;
   localparam int WAY_FIELD_W = 4;
   localparam int DC_W = 2;
   localparam int CNT_W = 16;
   localparam int K_W = 5;

   localparam logic [0:0] REQ_QUERY = 1'b0;
   localparam logic [0:0] REQ_UPDATE = 1'b1;

   localparam logic [0:0] CSR_THRESHOLD = 1'b0;
   localparam logic [0:0] CSR_DECAY = 1'b1;

   typedef enum logic [2:0] {
      OP_IDLE,
      OP_CLEAR,
      OP_READ,
      OP_HIST,
      OP_SCAN,
      OP_WRITE,
      OP_DECAY,
      OP_DECAY_WB
   } op_type;

   typedef struct packed {
      op_type op;
      logic   capture;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic hist_done;
      logic scan_done;
      logic decay_needed;
      logic decay_done;
   } status_type;
endpackage

### design/stream_aware_deadblock_replacement_core.sv
// Top level of the stream-aware dead-block replacement core.
//  channel | dir | contents
//  req     | in  | tdata: set_index, way, address, victim_valid, hit; tuser: req_type
//  rsp     | out | tdata: victim_way, set_streaming
//  csr     | in  | csr_index, csr_data
// A query reads the history serially on one RAM port, then scans up to 16 ways; an update
// reads the history the same way, then writes the set's stores.
// Every 2^k updates, k being the decay CSR value capped at 16, a decay sweep runs with one row
// read and one write per set.
// After reset a clearing pass over every set and history entry runs before any request.
// One request is in flight; req_tready stays low until the response is taken.
module stream_aware_deadblock_replacement_core #(
   parameter int NUM_SETS = 2048,
   parameter int NUM_WAYS = 16,
   parameter int LEADER_SETS = 32,
   parameter int HISTORY_DEPTH = 4,
   parameter int SELECTOR_BITS = 10,
   parameter int BIMODAL_PERIOD = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // set_index[10:0], way[14:11], address[78:15], victim_valid[79], hit[80], pad
   input  logic [87:0] req_tdata,
   // req_type[0]
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // victim_way[3:0], set_streaming[4], pad
   output logic [7:0]  rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [4:0]  csr_data
);
   import sadr_pkg::*;

   cmd_type cmd;
   status_type status;
   logic [WAY_FIELD_W-1:0] vway;
   logic strm;

   assign csr_ready = 1'b1;
   assign rsp_tdata = {3'b000, strm, vway};

   sadr_ctrl u_ctrl (
      .clock, .reset, .req_tvalid, .req_tready,
      .req_is_update(req_tuser == REQ_UPDATE),
      .rsp_tvalid, .rsp_tready, .status, .cmd);

   sadr_dp #(
      .NUM_SETS(NUM_SETS), .NUM_WAYS(NUM_WAYS), .LEADER_SETS(LEADER_SETS),
      .HISTORY_DEPTH(HISTORY_DEPTH), .SELECTOR_BITS(SELECTOR_BITS),
      .BIMODAL_PERIOD(BIMODAL_PERIOD)
   ) u_dp (
      .clock, .reset, .cmd, .status,
      .in_set(req_tdata[10:0]), .in_way(req_tdata[14:11]),
      .in_address(req_tdata[78:15]), .in_victim_valid(req_tdata[79]),
      .in_hit(req_tdata[80]),
      .csr_we(csr_valid && csr_ready), .csr_sel(csr_index), .csr_data(csr_data),
      .out_victim_way(vway), .out_streaming(strm));
endmodule

### design/sadr_ram.sv
// Generic single-port write, single-port read RAM with registered read.
module sadr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

### design/sadr_ctrl.sv
// Sequencer for requests, the clearing pass and the decay sweep.
module sadr_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic                req_is_update,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  sadr_pkg::status_type status,
   output sadr_pkg::cmd_type    cmd
);
   import sadr_pkg::*;

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_READ, ST_HIST, ST_SCAN, ST_WRITE, ST_DECAY, ST_DECAY_WB
   } state_type;

   state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic is_update_ff, is_update_in;

   // A new request is taken only once the previous response has left.
   assign req_tready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      is_update_in = is_update_ff;
      cmd.op = OP_IDLE;
      cmd.capture = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.op = OP_CLEAR;
            if (status.clear_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_tvalid && req_tready) begin
               cmd.capture = 1'b1;
               is_update_in = req_is_update;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            cmd.op = OP_READ;
            state_in = ST_HIST;
         end
         ST_HIST: begin
            cmd.op = OP_HIST;
            if (status.hist_done) state_in = is_update_ff ? ST_WRITE : ST_SCAN;
         end
         ST_SCAN: begin
            cmd.op = OP_SCAN;
            if (status.scan_done) begin
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_WRITE: begin
            cmd.op = OP_WRITE;
            if (status.decay_needed) begin
               state_in = ST_DECAY;
            end else begin
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_DECAY: begin
            cmd.op = OP_DECAY;
            state_in = ST_DECAY_WB;
         end
         ST_DECAY_WB: begin
            cmd.op = OP_DECAY_WB;
            if (status.decay_done) begin
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end else begin
               state_in = ST_DECAY;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
         is_update_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         is_update_ff <= is_update_in;
      end
   end
endmodule

### design/sadr_dp.sv
// Datapath: per-set stores, dead-counter rows, history match and policy logic.
module sadr_dp #(
   parameter int NUM_SETS = 2048,
   parameter int NUM_WAYS = 16,
   parameter int LEADER_SETS = 32,
   parameter int HISTORY_DEPTH = 4,
   parameter int SELECTOR_BITS = 10,
   parameter int BIMODAL_PERIOD = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  sadr_pkg::cmd_type                 cmd,
   output sadr_pkg::status_type              status,
   input  logic [sadr_pkg::SET_FIELD_W-1:0]  in_set,
   input  logic [sadr_pkg::WAY_FIELD_W-1:0]  in_way,
   input  logic [sadr_pkg::ADDR_W-1:0]       in_address,
   input  logic                              in_victim_valid,
   input  logic                              in_hit,
   input  logic                              csr_we,
   input  logic                              csr_sel,
   input  logic [sadr_pkg::K_W-1:0]          csr_data,
   output logic [sadr_pkg::WAY_FIELD_W-1:0]  out_victim_way,
   output logic                              out_streaming
);
   import sadr_pkg::*;

   localparam int SET_W = $clog2(NUM_SETS);
   localparam int HP_W = $clog2(HISTORY_DEPTH);
   localparam int ROW_W = NUM_WAYS * DC_W;
   localparam int WAY_W = $clog2(NUM_WAYS);
   localparam int SCAN_LIM = (NUM_WAYS < 16) ? NUM_WAYS : 16;
   localparam int SCAN_W = $clog2(SCAN_LIM + 1);
   localparam int BIM_W = $clog2(BIMODAL_PERIOD);
   localparam int PSET_W = ADDR_W + HP_W + 2;
   localparam logic [SELECTOR_BITS-1:0] SEL_MID = SELECTOR_BITS'(1) << (SELECTOR_BITS - 1);
   localparam logic [SELECTOR_BITS-1:0] SEL_MAX = '1;

   // Captured request.
   logic [SET_W-1:0] set_ff;
   logic [WAY_FIELD_W-1:0] way_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic vv_ff, hit_ff;
   logic [1:0] thr_ff;
   logic [K_W-1:0] kcfg_ff;
   logic [SELECTOR_BITS-1:0] sel_ff;
   logic [CNT_W-1:0] ucnt_ff;
   logic [BIM_W-1:0] bim_ff;

   // Memories.
   logic pset_we, row_we, hist_we;
   logic [SET_W-1:0] pset_wa, pset_ra, row_wa, row_ra;
   logic [PSET_W-1:0] pset_wd, pset_rd;
   logic [ROW_W-1:0] row_wd, row_rd;
   logic [SET_W+HP_W-1:0] hist_wa, hist_ra;
   logic [ADDR_W-1:0] hist_wd, hist_rd;

   sadr_ram #(.WIDTH(PSET_W), .DEPTH(NUM_SETS)) u_pset (
      .clock, .wr_en(pset_we), .wr_addr(pset_wa), .wr_data(pset_wd),
      .rd_addr(pset_ra), .rd_data(pset_rd));
   sadr_ram #(.WIDTH(ROW_W), .DEPTH(NUM_SETS)) u_rows (
      .clock, .wr_en(row_we), .wr_addr(row_wa), .wr_data(row_wd),
      .rd_addr(row_ra), .rd_data(row_rd));
   sadr_ram #(.WIDTH(ADDR_W), .DEPTH(NUM_SETS * HISTORY_DEPTH)) u_hist (
      .clock, .wr_en(hist_we), .wr_addr(hist_wa), .wr_data(hist_wd),
      .rd_addr(hist_ra), .rd_data(hist_rd));

   // Sweep counter for the clearing pass and decay; history step counter.
   logic [SET_W:0] sweep_ff, sweep_in;
   logic [HP_W:0] hstep_ff, hstep_in;
   logic [HP_W:0] hrd_idx;
   logic [ADDR_W-1:0] h0_ff;
   logic [HP_W:0] match_ff;
   logic [SCAN_W-1:0] scan_ff;
   logic [WAY_FIELD_W-1:0] vway_ff;
   logic stream_ff;

   // Per-set fields from the read word.
   logic [ADDR_W-1:0] prior_addr;
   logic [HP_W-1:0] hptr;
   logic [1:0] scnt;
   assign {prior_addr, hptr, scnt} = pset_rd;

   logic [ADDR_W-1:0] delta;
   logic [HP_W-1:0] hptr_next;
   assign delta = (prior_addr != '0) ? addr_ff - prior_addr : '0;
   assign hptr_next = (HP_W'(HISTORY_DEPTH - 1) == hptr) ? '0 : hptr + 1'b1;

   // History word as it stands after this update's write.
   logic [ADDR_W-1:0] hval;
   logic [HP_W:0] hprev;
   assign hprev = hstep_ff - 1'b1;
   assign hval = (hprev[HP_W-1:0] == hptr) ? delta : hist_rd;

   logic hist_last;
   assign hist_last = (hstep_ff == (HP_W+1)'(HISTORY_DEPTH));

   // Stream counter step.
   logic [1:0] scnt_new;
   logic matched;
   assign matched = match_ff >= (HP_W+1)'(thr_ff);
   always_comb begin
      if (matched) scnt_new = (scnt == 2'd3) ? scnt : scnt + 2'd1;
      else scnt_new = (scnt == 2'd0) ? scnt : scnt - 2'd1;
   end

   logic [CNT_W-1:0] ucnt_next;
   logic [K_W-1:0] k_eff;
   logic [CNT_W-1:0] kmask;
   assign ucnt_next = ucnt_ff + 1'b1;
   assign k_eff = (kcfg_ff > K_W'(16)) ? K_W'(16) : kcfg_ff;
   assign kmask = CNT_W'((17'(1) << k_eff) - 17'(1));

   logic lead_lip, lead_bip, lip;
   assign lead_lip = set_ff < SET_W'(LEADER_SETS);
   assign lead_bip = set_ff >= SET_W'(NUM_SETS - LEADER_SETS);
   assign lip = lead_lip || (!lead_bip && sel_ff >= SEL_MID);

   logic line_ok;
   assign line_ok = {1'b0, way_ff} < (WAY_FIELD_W+1)'(NUM_WAYS);
   logic [WAY_W-1:0] way_idx;
   assign way_idx = way_ff[WAY_W-1:0];
   logic [DC_W-1:0] dc_old, dc_new;
   assign dc_old = row_rd[way_idx*DC_W +: DC_W];

   logic [BIM_W-1:0] bim_next;
   logic fill_policy;
   assign bim_next = (bim_ff == BIM_W'(BIMODAL_PERIOD - 1)) ? '0 : bim_ff + 1'b1;
   assign fill_policy = !hit_ff && (scnt_new < 2'd2);
   always_comb begin
      logic [DC_W-1:0] v;
      v = lip ? 2'd0 : ((bim_next == '0) ? 2'd0 : 2'd1);
      if (vv_ff) v = v + 2'd1;
      if (hit_ff) dc_new = (dc_old != 0) ? dc_old - 2'd1 : dc_old;
      else if (scnt_new >= 2'd2) dc_new = 2'd3;
      else dc_new = v;
   end

   // A fill's line is written before the sweep and left alone by it, as if set after the decay.
   logic hold_line;
   assign hold_line = line_ok && !hit_ff && (sweep_ff[SET_W-1:0] == set_ff);

   logic [ROW_W-1:0] row_upd, row_dec;
   always_comb begin
      row_upd = row_rd;
      if (line_ok) row_upd[way_idx*DC_W +: DC_W] = dc_new;
      for (int w = 0; w < NUM_WAYS; w++) begin
         if (hold_line && WAY_W'(w) == way_idx)
            row_dec[w*DC_W +: DC_W] = row_rd[w*DC_W +: DC_W];
         else
            row_dec[w*DC_W +: DC_W] = (row_rd[w*DC_W +: DC_W] != 0) ?
               row_rd[w*DC_W +: DC_W] - 2'd1 : 2'd0;
      end
   end

   logic [SET_W-1:0] sweep_set;
   assign sweep_set = sweep_ff[SET_W-1:0];
   assign hrd_idx = (cmd.op == OP_READ) ? '0 : hstep_ff;

   always_comb begin
      pset_we = 1'b0; row_we = 1'b0; hist_we = 1'b0;
      pset_wa = set_ff; row_wa = set_ff; hist_wa = {set_ff, hptr};
      pset_wd = {addr_ff, hptr_next, scnt_new};
      row_wd = row_upd; hist_wd = delta;
      pset_ra = set_ff; row_ra = set_ff;
      hist_ra = {set_ff, hrd_idx[HP_W-1:0]};
      sweep_in = sweep_ff;
      hstep_in = hstep_ff;
      case (cmd.op)
         OP_CLEAR: begin
            pset_we = 1'b1; row_we = 1'b1; hist_we = 1'b1;
            pset_wa = sweep_set; row_wa = sweep_set; pset_wd = '0; row_wd = '0;
            hist_wd = '0;
            hist_wa = {sweep_set, hstep_ff[HP_W-1:0]};
            if (hstep_ff == (HP_W+1)'(HISTORY_DEPTH - 1)) begin
               hstep_in = '0;
               sweep_in = sweep_ff + 1'b1;
            end else begin
               hstep_in = hstep_ff + 1'b1;
            end
         end
         OP_READ: hstep_in = (HP_W+1)'(1);
         OP_HIST: begin
            if (!hist_last) hstep_in = hstep_ff + 1'b1;
         end
         OP_WRITE: begin
            pset_we = 1'b1;
            row_we = 1'b1;
            hist_we = 1'b1;
            sweep_in = '0;
            row_ra = '0;
         end
         OP_DECAY: row_ra = sweep_set;
         OP_DECAY_WB: begin
            row_we = 1'b1; row_wa = sweep_set; row_wd = row_dec;
            sweep_in = sweep_ff + 1'b1;
            row_ra = SET_W'(sweep_ff + 1'b1);
         end
         default: ;
      endcase
   end

   assign status.clear_done = (sweep_ff == (SET_W+1)'(NUM_SETS - 1)) &&
                              (hstep_ff == (HP_W+1)'(HISTORY_DEPTH - 1));
   assign status.hist_done = hist_last;
   assign status.scan_done = (scan_ff == SCAN_W'(SCAN_LIM)) ||
                             (row_rd[scan_ff[WAY_W-1:0]*DC_W +: DC_W] == 2'd3);
   assign status.decay_needed = (ucnt_next & kmask) == '0;
   assign status.decay_done = sweep_ff == (SET_W+1)'(NUM_SETS - 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= 2'd3;
         kcfg_ff <= K_W'(8);
         sel_ff <= SEL_MID;
         ucnt_ff <= '0;
         bim_ff <= '0;
         sweep_ff <= '0;
         hstep_ff <= '0;
      end else begin
         sweep_ff <= sweep_in;
         hstep_ff <= hstep_in;
         if (csr_we) begin
            if (csr_sel == CSR_THRESHOLD) thr_ff <= csr_data[1:0];
            else kcfg_ff <= csr_data;
         end
         if (cmd.op == OP_WRITE) begin
            ucnt_ff <= ucnt_next;
            if (fill_policy) begin
               if (!lip) bim_ff <= bim_next;
               if (lead_lip && sel_ff != SEL_MAX) sel_ff <= sel_ff + 1'b1;
               else if (lead_bip && sel_ff != '0) sel_ff <= sel_ff - 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         set_ff <= in_set[SET_W-1:0];
         way_ff <= in_way;
         addr_ff <= in_address;
         vv_ff <= in_victim_valid;
         hit_ff <= in_hit;
      end
      if (cmd.op == OP_HIST) begin
         if (hprev == '0) begin
            h0_ff <= hval;
            match_ff <= '0;
         end else if (hval == h0_ff && h0_ff != '0) begin
            match_ff <= match_ff + 1'b1;
         end
         scan_ff <= '0;
         stream_ff <= scnt >= 2'd2;
      end
      if (cmd.op == OP_SCAN) begin
         if (status.scan_done) begin
            vway_ff <= (scan_ff == SCAN_W'(SCAN_LIM)) ? '0 : WAY_FIELD_W'(scan_ff);
         end else begin
            scan_ff <= scan_ff + 1'b1;
         end
      end
      if (cmd.op == OP_WRITE) begin
         vway_ff <= '0;
         stream_ff <= scnt_new >= 2'd2;
      end
   end

   assign out_victim_way = vway_ff;
   assign out_streaming = stream_ff;
endmodule

### design/sadr_checker.sv
// Port-level checks for the replacement core, bound to the top level.
module sadr_port_props (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       req_tuser,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata
);
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("request taken while response pending");
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready) else $error("second request taken");
   a_update_way0: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser) |=> ##3 (!rsp_tvalid || rsp_tdata[3:0] == 4'd0))
      else $error("update response with nonzero way");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("response dropped while stalled");
endmodule

bind stream_aware_deadblock_replacement_core sadr_port_props u_checker (
   .clock, .reset, .req_tvalid, .req_tready, .req_tuser,
   .rsp_tvalid, .rsp_tready, .rsp_tdata);
